// ===== rtl/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants for the aging priority scheduler
//
// Request and response structs, slot status codes, event kinds, cell
// ops, the broadcast command and the token passed along the cell row.
// ----------------------------------------------------------------------------
package aps_pkg;

  // Slot index width along the row (covers the largest supported slot count)
  localparam int unsigned SLOT_IDX_W = 5;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned SUM_W      = 17;

  localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

  // Slot status codes
  localparam logic [2:0] ST_CREATED    = 3'd1;
  localparam logic [2:0] ST_READY      = 3'd2;
  localparam logic [2:0] ST_EXECUTING  = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;

  // Event kinds
  localparam logic [2:0] KIND_SCHEDULE = 3'd0;
  localparam logic [2:0] KIND_EXIT     = 3'd1;
  localparam logic [2:0] KIND_KILL     = 3'd2;
  localparam logic [2:0] KIND_NICE     = 3'd3;
  localparam logic [2:0] KIND_FORK     = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        target_pid;
    logic [PRIO_W-1:0] nice_prio;
  } req_t;

  typedef struct packed {
    logic [2:0] from_pid;
    logic [2:0] to_pid;
    logic       switched;
    logic [2:0] forked_pid;
    logic       fork_failed;
  } rsp_t;

  // Operations broadcast to every cell
  typedef enum logic [2:0] {
    OP_NOP,
    OP_EXIT,
    OP_TERMINATE,
    OP_KILL_ALL,
    OP_SET_PRIO,
    OP_DECIDE,
    OP_FORK
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [SLOT_IDX_W-1:0] slot;  // target, chosen or claimed slot
    logic [SLOT_IDX_W-1:0] run;   // running slot before the decision
    logic [PRIO_W-1:0]     prio;
  } cell_cmd_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  e_found;
    logic [SUM_W-1:0]      e_sum;
    logic [SLOT_IDX_W-1:0] e_idx;
    logic                  c_found;
    logic [SLOT_IDX_W-1:0] c_idx;
  } tok_t;

endpackage

// ===== rtl/aps_cell.sv =====
// ----------------------------------------------------------------------------
// aps_cell: one process slot of the scheduler row
//
// Holds the slot's status, priority and age, applies broadcast commands and
// passes the search token on to its neighbor through a register each cycle.
// ----------------------------------------------------------------------------
module aps_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aps_pkg::cell_cmd_t cmd_i,
  input  aps_pkg::tok_t     tok_i,
  output aps_pkg::tok_t     tok_o
);

  logic [2:0]                 status_q, status_d;
  logic [aps_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [aps_pkg::AGE_W-1:0]  age_q, age_d;
  aps_pkg::tok_t              tok_q, tok_d;

  logic                       eligible;
  logic                       is_slot;
  logic                       is_run;
  logic [aps_pkg::SUM_W-1:0]  sum;

  assign eligible = (status_q == aps_pkg::ST_READY) || (status_q == aps_pkg::ST_EXECUTING);
  assign is_slot  = (cmd_i.slot == aps_pkg::SLOT_IDX_W'(INDEX));
  assign is_run   = (cmd_i.run == aps_pkg::SLOT_IDX_W'(INDEX));
  assign sum      = aps_pkg::SUM_W'(prio_q) + aps_pkg::SUM_W'(age_q);

  // Token: best eligible sum so far, first created slot so far
  always_comb begin
    tok_d = tok_i;
    if (eligible && (!tok_i.e_found || (sum > tok_i.e_sum))) begin
      tok_d.e_found = 1'b1;
      tok_d.e_sum   = sum;
      tok_d.e_idx   = aps_pkg::SLOT_IDX_W'(INDEX);
    end
    if ((status_q == aps_pkg::ST_CREATED) && !tok_i.c_found) begin
      tok_d.c_found = 1'b1;
      tok_d.c_idx   = aps_pkg::SLOT_IDX_W'(INDEX);
    end
  end

  // Slot state update
  always_comb begin
    status_d = status_q;
    prio_d   = prio_q;
    age_d    = age_q;
    case (cmd_i.op)
      aps_pkg::OP_EXIT: begin
        if (is_slot) begin
          status_d = aps_pkg::ST_TERMINATED;
          age_d    = '0;
        end
      end
      aps_pkg::OP_TERMINATE: begin
        if (is_slot) begin
          status_d = aps_pkg::ST_TERMINATED;
          prio_d   = aps_pkg::PRIO_W'(1);
          age_d    = '0;
        end
      end
      aps_pkg::OP_KILL_ALL: begin
        // console slot is spared
        if ((INDEX != 0) && eligible) begin
          status_d = aps_pkg::ST_TERMINATED;
          prio_d   = aps_pkg::PRIO_W'(1);
          age_d    = '0;
        end
      end
      aps_pkg::OP_SET_PRIO: begin
        if (is_slot) begin
          prio_d = cmd_i.prio;
        end
      end
      aps_pkg::OP_DECIDE: begin
        if (is_slot) begin
          status_d = aps_pkg::ST_EXECUTING;
          age_d    = '0;
        end else begin
          if (eligible && (age_q != aps_pkg::AGE_MAX)) begin
            age_d = age_q + aps_pkg::AGE_W'(1);
          end
          if (is_run && (status_q != aps_pkg::ST_TERMINATED)) begin
            status_d = aps_pkg::ST_READY;
          end
        end
      end
      aps_pkg::OP_FORK: begin
        if (is_slot) begin
          status_d = aps_pkg::ST_READY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= (INDEX == 0) ? aps_pkg::ST_READY : aps_pkg::ST_CREATED;
      prio_q   <= (INDEX == 0) ? aps_pkg::PRIO_W'(2) : aps_pkg::PRIO_W'(1);
      age_q    <= '0;
      tok_q    <= '0;
    end else begin
      status_q <= status_d;
      prio_q   <= prio_d;
      age_q    <= age_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/aging_priority_process_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// aging_priority_process_scheduler_top: aging priority process scheduler
//
// Row of slot cells with a small sequencer that runs one event at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in channel:  in_valid_i / in_stall_o / in_req_i carry one event request
//                (kind, target_pid, nice_prio). A request is taken at a
//                clock edge with valid high and stall low.
//   out channel: out_valid_o / out_stall_i / out_rsp_o carry one response per
//                request (from_pid, to_pid, switched, forked_pid,
//                fork_failed).
//   Sequence: after a request is taken, the sequencer applies exit, kill or
//   nice, then carries the search token down the cell row (one cell per
//   cycle), then applies the decision or fork claim and registers the
//   response.
//   Flow: one request in flight; the next request is taken only once the
//   response has been handed over from the output register.
//   The input stalls while a request is in flight and while a response waits
//   in the output register; a stalled response holds its value.
//   Reset: slot 0 ready with priority 2 and running, other slots created with
//   priority 1, all ages zero, both channels empty.
// ----------------------------------------------------------------------------
module aging_priority_process_scheduler_top #(
  parameter int unsigned PROCESS_SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  aps_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output aps_pkg::rsp_t out_rsp_o
);

  localparam int unsigned IDX_W = $clog2(PROCESS_SLOTS);
  localparam int unsigned CNT_W = $clog2(PROCESS_SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRE   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   run_q, run_d;
  aps_pkg::req_t      req_q;
  logic               out_valid_q, out_valid_d;
  aps_pkg::rsp_t      rsp_q, rsp_d;

  aps_pkg::cell_cmd_t cmd;
  aps_pkg::tok_t      chain [PROCESS_SLOTS+1];
  aps_pkg::tok_t      tok_end;
  logic               in_take;
  logic               pid_ok;
  logic               decides;
  logic [31:0]        run_ext;
  logic [31:0]        best_ext;
  logic [31:0]        fork_ext;

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_take    = in_valid_i && !in_stall_o;
  assign pid_ok     = (32'(req_q.target_pid) < PROCESS_SLOTS);
  assign decides    = (req_q.kind == aps_pkg::KIND_SCHEDULE) ||
                      (req_q.kind == aps_pkg::KIND_EXIT) ||
                      (req_q.kind == aps_pkg::KIND_NICE);
  assign tok_end    = chain[PROCESS_SLOTS];
  assign run_ext    = 32'(run_q);
  assign best_ext   = 32'(tok_end.e_idx);
  assign fork_ext   = 32'(tok_end.c_idx);

  // Cell row: search token enters empty at slot 0
  assign chain[0] = '0;

  for (genvar g = 0; g < PROCESS_SLOTS; g++) begin : g_cell
    aps_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  // Command broadcast to the row
  always_comb begin
    cmd      = '0;
    cmd.op   = aps_pkg::OP_NOP;
    cmd.run  = aps_pkg::SLOT_IDX_W'(run_q);
    cmd.prio = req_q.nice_prio;
    if (state_q == S_PRE) begin
      case (req_q.kind)
        aps_pkg::KIND_EXIT: begin
          cmd.op   = aps_pkg::OP_EXIT;
          cmd.slot = aps_pkg::SLOT_IDX_W'(run_q);
        end
        aps_pkg::KIND_KILL: begin
          cmd.slot = aps_pkg::SLOT_IDX_W'(req_q.target_pid);
          if (req_q.target_pid == 3'd0) begin
            cmd.op = aps_pkg::OP_KILL_ALL;
          end else if (pid_ok) begin
            cmd.op = aps_pkg::OP_TERMINATE;
          end
        end
        aps_pkg::KIND_NICE: begin
          cmd.slot = aps_pkg::SLOT_IDX_W'(req_q.target_pid);
          if (pid_ok) begin
            cmd.op = aps_pkg::OP_SET_PRIO;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == S_APPLY) begin
      if (decides && tok_end.e_found) begin
        cmd.op   = aps_pkg::OP_DECIDE;
        cmd.slot = tok_end.e_idx;
      end else if ((req_q.kind == aps_pkg::KIND_FORK) && tok_end.c_found) begin
        cmd.op   = aps_pkg::OP_FORK;
        cmd.slot = tok_end.c_idx;
      end
    end
  end

  // Sequencer and response register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && out_stall_i;
    rsp_d       = rsp_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        cnt_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (32'(cnt_q) == PROCESS_SLOTS - 1) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        rsp_d            = '0;
        rsp_d.from_pid   = run_ext[2:0];
        rsp_d.to_pid     = run_ext[2:0];
        if (decides) begin
          rsp_d.switched = 1'b1;
          if (tok_end.e_found) begin
            run_d        = IDX_W'(tok_end.e_idx);
            rsp_d.to_pid = best_ext[2:0];
          end
        end
        if (req_q.kind == aps_pkg::KIND_FORK) begin
          if (tok_end.c_found) begin
            rsp_d.forked_pid = fork_ext[2:0];
          end else begin
            rsp_d.fork_failed = 1'b1;
          end
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/aps_checker.sv =====
// ----------------------------------------------------------------------------
// aps_checker: port-level checks for the aging priority scheduler
//
// Watches the request and response channels of the top level; attached by
// the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module aps_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input aps_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input aps_pkg::rsp_t out_rsp_o
);

  // A stalled response keeps its value
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response changed");

  // A stalled request stays offered with the same payload
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_req_i)))
    else $error("stalled request changed");

  // Only one request is in flight: the input stalls right after a request
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // Without a scheduling decision the running slot does not change
  a_no_switch_same_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.switched) |-> (out_rsp_o.from_pid == out_rsp_o.to_pid))
    else $error("running slot changed without a decision");

  // A failed fork reports no slot and no decision
  a_fork_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.fork_failed) |->
    ((out_rsp_o.forked_pid == 3'd0) && !out_rsp_o.switched))
    else $error("failed fork reported a slot or a decision");

endmodule

bind aging_priority_process_scheduler_top aps_checker u_aps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o)
);

// ===== sim/tb_aging_priority_process_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_aging_priority_process_scheduler_top: testbench for the aging scheduler
//
// Drives schedule, exit, kill, nice, fork and reserved requests; a slot
// table kept here predicts each response, and every response is checked
// field by field in arrival order. Directed tests open and close the run;
// random traffic under changing idle and stall patterns runs between them.
// ----------------------------------------------------------------------------
module tb_aging_priority_process_scheduler_top;

  localparam int unsigned NSLOTS          = 8;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned MAX_REPORTS     = 10;

  // Kinds the scheduler ignores
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  // Kill target that means every slot except the console
  localparam logic [2:0] PID_ALL = 3'd0;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  aps_pkg::req_t in_req_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  aps_pkg::rsp_t out_rsp_o;

  // Idle and stall rates in percent
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // Expected responses, oldest first
  aps_pkg::rsp_t outcome_q[$];

  // Predicted slot table
  logic [2:0]                 sched_status [NSLOTS];
  logic [aps_pkg::PRIO_W-1:0] sched_prio   [NSLOTS];
  logic [aps_pkg::AGE_W-1:0]  sched_age    [NSLOTS];
  logic [2:0]                 sched_running;

  aging_priority_process_scheduler_top #(
    .PROCESS_SLOTS(NSLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Slot table prediction
  // --------------------------------------------------------------------------
  function automatic void reset_slot_table();
    int i;
    for (i = 0; i < NSLOTS; i++) begin
      sched_status[i] = (i == 0) ? aps_pkg::ST_READY : aps_pkg::ST_CREATED;
      sched_prio[i]   = (i == 0) ? 8'd2 : 8'd1;
      sched_age[i]    = '0;
    end
    sched_running = '0;
  endfunction

  function automatic bit slot_runnable(int i);
    return sched_status[i] == aps_pkg::ST_READY || sched_status[i] == aps_pkg::ST_EXECUTING;
  endfunction

  function automatic void retire_slot(int i);
    sched_status[i] = aps_pkg::ST_TERMINATED;
    sched_prio[i]   = 8'd1;
    sched_age[i]    = '0;
  endfunction

  // Pick the highest priority plus age, lowest index on a tie, then age the rest
  function automatic void run_decision();
    int          i;
    int          best;
    logic [16:0] best_sum;
    logic [16:0] sum;
    bit          found;
    best     = 0;
    best_sum = '0;
    found    = 1'b0;
    for (i = 0; i < NSLOTS; i++) begin
      if (slot_runnable(i)) begin
        sum = {9'd0, sched_prio[i]} + {1'b0, sched_age[i]};
        if (!found || sum > best_sum) begin
          best     = i;
          best_sum = sum;
          found    = 1'b1;
        end
      end
    end
    if (!found) return;
    for (i = 0; i < NSLOTS; i++) begin
      if (i != best && slot_runnable(i) && sched_age[i] != aps_pkg::AGE_MAX)
        sched_age[i] = sched_age[i] + 16'd1;
    end
    sched_age[best] = '0;
    if (sched_running != 3'(best) && sched_status[sched_running] != aps_pkg::ST_TERMINATED)
      sched_status[sched_running] = aps_pkg::ST_READY;
    sched_status[best] = aps_pkg::ST_EXECUTING;
    sched_running      = 3'(best);
  endfunction

  // Apply one request to the table and return the response it should produce
  function automatic aps_pkg::rsp_t next_schedule_outcome(aps_pkg::req_t r);
    aps_pkg::rsp_t o;
    int            i;
    bit            claimed;
    o          = '0;
    o.from_pid = sched_running;
    claimed    = 1'b0;
    case (r.kind)
      aps_pkg::KIND_SCHEDULE: begin
        run_decision();
        o.switched = 1'b1;
      end
      aps_pkg::KIND_EXIT: begin
        sched_status[sched_running] = aps_pkg::ST_TERMINATED;
        sched_age[sched_running]    = '0;
        run_decision();
        o.switched = 1'b1;
      end
      aps_pkg::KIND_KILL: begin
        if (r.target_pid == PID_ALL) begin
          for (i = 1; i < NSLOTS; i++)
            if (slot_runnable(i)) retire_slot(i);
        end else begin
          retire_slot(r.target_pid);
        end
      end
      aps_pkg::KIND_NICE: begin
        sched_prio[r.target_pid] = r.nice_prio;
        run_decision();
        o.switched = 1'b1;
      end
      aps_pkg::KIND_FORK: begin
        for (i = 0; i < NSLOTS && !claimed; i++) begin
          if (sched_status[i] == aps_pkg::ST_CREATED) begin
            sched_status[i] = aps_pkg::ST_READY;
            o.forked_pid    = 3'(i);
            claimed         = 1'b1;
          end
        end
        o.fork_failed = !claimed;
      end
      default: ;
    endcase
    o.to_pid = sched_running;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Response checking
  // --------------------------------------------------------------------------
  function automatic void log_failure(string what, aps_pkg::rsp_t want, aps_pkg::rsp_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected from=%0d to=%0d sw=%0d fork=%0d fail=%0d",
               $realtime, what, want.from_pid, want.to_pid, want.switched,
               want.forked_pid, want.fork_failed);
      $display("    got from=%0d to=%0d sw=%0d fork=%0d fail=%0d",
               got.from_pid, got.to_pid, got.switched, got.forked_pid,
               got.fork_failed);
    end
  endfunction

  function automatic void check_outcome(aps_pkg::rsp_t got);
    aps_pkg::rsp_t want;
    string         bad;
    if (outcome_q.size() == 0) begin
      log_failure("response with nothing outstanding", got, got);
      return;
    end
    want = outcome_q.pop_front();
    bad  = "";
    if (got.from_pid !== want.from_pid)       bad = {bad, " from_pid"};
    if (got.to_pid !== want.to_pid)           bad = {bad, " to_pid"};
    if (got.switched !== want.switched)       bad = {bad, " switched"};
    if (got.forked_pid !== want.forked_pid)   bad = {bad, " forked_pid"};
    if (got.fork_failed !== want.fork_failed) bad = {bad, " fork_failed"};
    if (bad != "") log_failure({"mismatch on", bad}, want, got);
  endfunction

  // Check responses, drive the output stall, and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_outcome(out_rsp_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  task automatic send_event(input aps_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    outcome_q.push_back(next_schedule_outcome(r));
  endtask

  task automatic send_fields(input logic [2:0] kind, input logic [2:0] pid,
                             input logic [7:0] prio);
    aps_pkg::req_t r;
    r.kind       = kind;
    r.target_pid = pid;
    r.nice_prio  = prio;
    send_event(r);
  endtask

  // Stop sending and let every outstanding response come back
  task automatic wait_for_outcomes();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [2:0] reserved_kind();
    case ($urandom_range(0, 2))
      0:       return KIND_RSVD5;
      1:       return KIND_RSVD6;
      default: return KIND_RSVD7;
    endcase
  endfunction

  // Mild traffic keeps slots alive; harsh traffic kills and exits often
  function automatic aps_pkg::req_t random_event(bit harsh);
    aps_pkg::req_t r;
    int unsigned   roll;
    r.target_pid = 3'($urandom_range(0, 7));
    r.nice_prio  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (!harsh) begin
      if (roll < 45)      r.kind = aps_pkg::KIND_SCHEDULE;
      else if (roll < 80) r.kind = aps_pkg::KIND_NICE;
      else if (roll < 92) r.kind = aps_pkg::KIND_FORK;
      else if (roll < 96) r.kind = reserved_kind();
      else if (roll < 99) begin
        r.kind = aps_pkg::KIND_KILL;
        if (r.target_pid == PID_ALL) r.target_pid = 3'($urandom_range(1, 7));
      end else begin
        r.kind = aps_pkg::KIND_EXIT;
      end
    end else begin
      if (roll < 40)      r.kind = aps_pkg::KIND_SCHEDULE;
      else if (roll < 60) r.kind = aps_pkg::KIND_NICE;
      else if (roll < 70) r.kind = aps_pkg::KIND_FORK;
      else if (roll < 75) r.kind = reserved_kind();
      else if (roll < 90) r.kind = aps_pkg::KIND_KILL;
      else                r.kind = aps_pkg::KIND_EXIT;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Decision on the reset table, then the ignored kinds with extreme fields
  task automatic test_reset_and_reserved();
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    send_fields(KIND_RSVD5, 3'd7, 8'd255);
    send_fields(KIND_RSVD6, 3'd0, 8'd0);
    send_fields(KIND_RSVD7, 3'd5, 8'd170);
    wait_for_outcomes();
  endtask

  // Claim every created slot in order, then one fork that must fail
  task automatic test_fork_claims();
    int i;
    for (i = 0; i < NSLOTS; i++) send_fields(aps_pkg::KIND_FORK, 3'(i), 8'(i));
    wait_for_outcomes();
  endtask

  // Priority extremes against aging of the slots left waiting
  task automatic test_nice_and_aging();
    send_fields(aps_pkg::KIND_NICE, 3'd3, 8'd255);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_NICE, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd7, 8'd255);
    send_fields(aps_pkg::KIND_NICE, 3'd3, 8'd0);
    wait_for_outcomes();
  endtask

  // Kill a waiting slot, kill the running slot, then exit
  task automatic test_kill_and_exit();
    send_fields(aps_pkg::KIND_KILL, 3'd7, 8'd0);
    wait_for_outcomes();
    send_fields(aps_pkg::KIND_KILL, sched_running, 8'd255);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_EXIT, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    wait_for_outcomes();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned busy_pct,
                                     input int unsigned count, input bit harsh);
    int unsigned n;
    // hold off until the pipe is empty before switching pattern
    wait_for_outcomes();
    send_idle_pct = idle_pct;
    stall_pct     = busy_pct;
    for (n = 0; n < count; n++) send_event(random_event(harsh));
    wait_for_outcomes();
  endtask

  // Kill all, exit the console, and run decisions with nothing eligible
  task automatic test_kill_all_and_starvation();
    send_fields(aps_pkg::KIND_KILL, PID_ALL, 8'd0);
    send_fields(aps_pkg::KIND_EXIT, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_NICE, 3'd0, 8'd200);
    send_fields(aps_pkg::KIND_FORK, 3'd0, 8'd0);
    send_fields(aps_pkg::KIND_KILL, PID_ALL, 8'd255);
    send_fields(aps_pkg::KIND_SCHEDULE, 3'd0, 8'd0);
    wait_for_outcomes();
  endtask

  initial begin
    reset_slot_table();
    send_idle_pct = 9;
    stall_pct     = 58;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_reserved();
    test_fork_claims();
    test_nice_and_aging();
    test_kill_and_exit();
    test_random_traffic(9, 58, 340, 1'b0);
    test_random_traffic(58, 9, 340, 1'b0);
    test_random_traffic(0, 0, 320, 1'b1);
    test_kill_all_and_starvation();

    // catch any response that shows up late or unasked
    repeat (NSLOTS + 4) @(posedge clk_i);
    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
